FILE: rtl/core/cre_pkg.sv
// Shared constants, codes and types of the rectangle fill engine.
package cre_pkg;

  // Screen dimensions above this value are treated as this value.
  localparam logic [12:0] MAX_DIM = 13'd4096;

  // Depth of the queue between the front end and the pixel walker.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Command codes on the func field.
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  // Pixel formats.
  localparam logic [1:0] FMT_32   = 2'd0;
  localparam logic [1:0] FMT_24   = 2'd1;
  localparam logic [1:0] FMT_565  = 2'd2;
  localparam logic [1:0] FMT_NONE = 2'd3;

  // Kinds of queue words.
  localparam logic [1:0] KIND_ADVANCE = 2'd0;
  localparam logic [1:0] KIND_FILL    = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROW_PITCH     = 3'd2;
  localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd3;
  localparam logic [2:0] REG_CLIP_ON       = 3'd4;
  localparam logic [2:0] REG_CLIP_X_BOUNDS = 3'd5;
  localparam logic [2:0] REG_CLIP_Y_BOUNDS = 3'd6;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [15:0] row_pitch;
    logic [1:0]  pixel_format;
    logic        clip_on;
    logic [25:0] clip_x_bounds;
    logic [25:0] clip_y_bounds;
  } cfg_t;

  // One classified command, as the pixel walker consumes it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] left;
    logic [12:0] right;
    logic [12:0] top;
    logic [12:0] bottom;
    logic [1:0]  fmt;
    logic [31:0] pixel;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_status_t;

endpackage

FILE: rtl/core/cre_if.sv
// Channel interfaces of the rectangle fill engine: commands, pixel writes, configuration.
interface cre_cmd_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic signed [15:0] rect_w;
  logic signed [15:0] rect_h;
  logic [31:0]        fill_color;

  modport source (output valid, func, rect_x, rect_y, rect_w, rect_h, fill_color,
                  input ready);
  modport sink (input valid, func, rect_x, rect_y, rect_w, rect_h, fill_color,
                output ready);
endinterface

interface cre_pix_if;
  logic        valid;
  logic        ready;
  logic [27:0] write_address;
  logic [31:0] write_data;
  logic [2:0]  write_bytes;
  logic        last_pixel;

  modport source (output valid, write_address, write_data, write_bytes, last_pixel,
                  input ready);
  modport sink (input valid, write_address, write_data, write_bytes, last_pixel,
                output ready);
endinterface

interface cre_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [25:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/clipped_rect_fill_engine.sv
// Solid rectangle fill engine with screen and window clipping (top level).
//
// A start word latches a clipped rectangle and its pixel; each advance word then
// yields one pixel write, left to right and top to bottom. Commands pass a two-stage
// clipping front end and a four-word queue before the pixel walker, which retires one
// queue word per cycle while no advance word waits on a stalled pixel port, so the
// engine then sustains one command and one pixel write per clock. The configuration
// port is always ready; the user must change registers only between fills, except
// row_pitch, which is sampled at each row change. The block does not enforce this.
module clipped_rect_fill_engine (
  input logic       clk,
  input logic       rst,
  cre_cmd_if.sink   cmd,
  cre_pix_if.source pix,
  cre_cfg_if.sink   cfg
);

  cre_pkg::cfg_t         cfg_regs;
  logic                  q_push;
  cre_pkg::cmd_t         q_in;
  logic                  q_full;
  logic                  q_pop;
  cre_pkg::cmd_t         q_head;
  logic                  q_valid;
  cre_pkg::back_status_t back_status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.screen_width  <= 13'd640;
      cfg_regs.screen_height <= 13'd480;
      cfg_regs.row_pitch     <= 16'd2560;
      cfg_regs.pixel_format  <= cre_pkg::FMT_32;
      cfg_regs.clip_on       <= 1'b0;
      cfg_regs.clip_x_bounds <= 26'd0;
      cfg_regs.clip_y_bounds <= 26'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        cre_pkg::REG_SCREEN_WIDTH:  cfg_regs.screen_width  <= cfg.data[12:0];
        cre_pkg::REG_SCREEN_HEIGHT: cfg_regs.screen_height <= cfg.data[12:0];
        cre_pkg::REG_ROW_PITCH:     cfg_regs.row_pitch     <= cfg.data[15:0];
        cre_pkg::REG_PIXEL_FORMAT:  cfg_regs.pixel_format  <= cfg.data[1:0];
        cre_pkg::REG_CLIP_ON:       cfg_regs.clip_on       <= cfg.data[0];
        cre_pkg::REG_CLIP_X_BOUNDS: cfg_regs.clip_x_bounds <= cfg.data;
        cre_pkg::REG_CLIP_Y_BOUNDS: cfg_regs.clip_y_bounds <= cfg.data;
        default: ;
      endcase
    end
  end

  cre_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .cmd      (cmd),
    .q_push   (q_push),
    .q_word   (q_in),
    .q_full   (q_full)
  );

  cre_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .valid (q_valid)
  );

  cre_back u_back (
    .clk       (clk),
    .rst       (rst),
    .row_pitch (cfg_regs.row_pitch),
    .q_valid   (q_valid),
    .q_word    (q_head),
    .q_pop     (q_pop),
    .status    (back_status),
    .pix       (pix)
  );

  // A new write appears only after the walker retired an advance word while busy.
  assert property (@(posedge clk) disable iff (rst)
    $rose(pix.valid) |-> $past(back_status.pop && back_status.busy &&
                               (q_head.kind == cre_pkg::KIND_ADVANCE)))
    else $error("pixel write without a retired advance word");

  // The walker never retires a word from an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    back_status.pop |-> q_valid)
    else $error("queue popped while empty");

  // A latched fill always makes the walker busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (back_status.pop && (q_head.kind == cre_pkg::KIND_FILL)) |=> back_status.busy)
    else $error("fill word did not start the walker");

  // A clear word always stops the walker.
  assert property (@(posedge clk) disable iff (rst)
    (back_status.pop && (q_head.kind == cre_pkg::KIND_CLEAR)) |=> !back_status.busy)
    else $error("clear word left the walker busy");

endmodule

FILE: rtl/core/cre_front.sv
// Front end: accepts commands, clips start rectangles and formats the fill pixel.
module cre_front (
  input  logic           clk,
  input  logic           rst,
  input  cre_pkg::cfg_t  cfg_regs,
  cre_cmd_if.sink        cmd,
  output logic           q_push,
  output cre_pkg::cmd_t  q_word,
  input  logic           q_full
);

  // Stage A: edge sums and effective bounds.
  logic               a_valid;
  logic               a_func;
  logic signed [17:0] a_x;
  logic signed [17:0] a_y;
  logic signed [17:0] a_x_end;
  logic signed [17:0] a_y_end;
  logic               a_size_ok;
  logic [1:0]         a_fmt;
  logic [31:0]        a_pixel;
  logic [12:0]        a_lo_x;
  logic [12:0]        a_hi_x;
  logic [12:0]        a_lo_y;
  logic [12:0]        a_hi_y;

  // Stage B: clipped command.
  logic               b_valid;
  cre_pkg::cmd_t      b_word;

  logic               a_ready;
  logic               b_ready;

  logic [12:0]        sw_eff;
  logic [12:0]        sh_eff;
  logic [12:0]        cx1;
  logic [12:0]        cx2;
  logic [12:0]        cy1;
  logic [12:0]        cy2;
  logic [12:0]        lo_x_c;
  logic [12:0]        hi_x_c;
  logic [12:0]        lo_y_c;
  logic [12:0]        hi_y_c;
  logic [31:0]        pixel_c;

  logic signed [17:0] lo_x_s;
  logic signed [17:0] hi_x_s;
  logic signed [17:0] lo_y_s;
  logic signed [17:0] hi_y_s;
  logic signed [17:0] x1;
  logic signed [17:0] x2;
  logic signed [17:0] y1;
  logic signed [17:0] y2;
  logic               empty;
  cre_pkg::cmd_t      word_c;

  assign b_ready   = !b_valid || !q_full;
  assign a_ready   = !a_valid || b_ready;
  assign cmd.ready = a_ready;
  assign q_push    = b_valid && !q_full;
  assign q_word    = b_word;

  always_comb begin
    sw_eff = (cfg_regs.screen_width > cre_pkg::MAX_DIM) ? cre_pkg::MAX_DIM
                                                        : cfg_regs.screen_width;
    sh_eff = (cfg_regs.screen_height > cre_pkg::MAX_DIM) ? cre_pkg::MAX_DIM
                                                         : cfg_regs.screen_height;
    cx1 = cfg_regs.clip_x_bounds[12:0];
    cx2 = cfg_regs.clip_x_bounds[25:13];
    cy1 = cfg_regs.clip_y_bounds[12:0];
    cy2 = cfg_regs.clip_y_bounds[25:13];
    lo_x_c = cfg_regs.clip_on ? cx1 : 13'd0;
    lo_y_c = cfg_regs.clip_on ? cy1 : 13'd0;
    hi_x_c = (cfg_regs.clip_on && (cx2 < sw_eff)) ? cx2 : sw_eff;
    hi_y_c = (cfg_regs.clip_on && (cy2 < sh_eff)) ? cy2 : sh_eff;
    case (cfg_regs.pixel_format)
      cre_pkg::FMT_32:  pixel_c = cmd.fill_color;
      cre_pkg::FMT_24:  pixel_c = {8'h00, cmd.fill_color[23:0]};
      cre_pkg::FMT_565: pixel_c = {16'h0000, cmd.fill_color[23:19],
                                   cmd.fill_color[15:10], cmd.fill_color[7:3]};
      default:          pixel_c = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= cmd.valid;
    end
    if (a_ready && cmd.valid) begin
      a_func    <= cmd.func;
      a_x       <= 18'(cmd.rect_x);
      a_y       <= 18'(cmd.rect_y);
      a_x_end   <= 18'(cmd.rect_x) + 18'(cmd.rect_w);
      a_y_end   <= 18'(cmd.rect_y) + 18'(cmd.rect_h);
      a_size_ok <= (cmd.rect_w > 16'sd0) && (cmd.rect_h > 16'sd0) &&
                   (cfg_regs.pixel_format != cre_pkg::FMT_NONE);
      a_fmt     <= cfg_regs.pixel_format;
      a_pixel   <= pixel_c;
      a_lo_x    <= lo_x_c;
      a_hi_x    <= hi_x_c;
      a_lo_y    <= lo_y_c;
      a_hi_y    <= hi_y_c;
    end
  end

  always_comb begin
    lo_x_s = $signed({5'b00000, a_lo_x});
    hi_x_s = $signed({5'b00000, a_hi_x});
    lo_y_s = $signed({5'b00000, a_lo_y});
    hi_y_s = $signed({5'b00000, a_hi_y});
    x1 = (a_x > lo_x_s) ? a_x : lo_x_s;
    y1 = (a_y > lo_y_s) ? a_y : lo_y_s;
    x2 = (a_x_end < hi_x_s) ? a_x_end : hi_x_s;
    y2 = (a_y_end < hi_y_s) ? a_y_end : hi_y_s;
    empty = !a_size_ok || (x2 <= x1) || (y2 <= y1);

    // A non-empty result lies inside the screen, so 13 bits hold every bound.
    word_c.left   = x1[12:0];
    word_c.right  = x2[12:0];
    word_c.top    = y1[12:0];
    word_c.bottom = y2[12:0];
    word_c.fmt    = a_fmt;
    word_c.pixel  = a_pixel;
    if (a_func == cre_pkg::FUNC_ADVANCE) begin
      word_c.kind = cre_pkg::KIND_ADVANCE;
    end else if (empty) begin
      word_c.kind = cre_pkg::KIND_CLEAR;
    end else begin
      word_c.kind = cre_pkg::KIND_FILL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_word <= word_c;
    end
  end

endmodule

FILE: rtl/core/cre_queue.sv
// Short command queue between the front end and the pixel walker.
module cre_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cre_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output cre_pkg::cmd_t dout,
  output logic          valid
);

  cre_pkg::cmd_t                 slots [cre_pkg::QUEUE_DEPTH];
  logic [cre_pkg::QUEUE_AW-1:0]  wptr;
  logic [cre_pkg::QUEUE_AW-1:0]  rptr;
  logic [cre_pkg::QUEUE_AW:0]    count;

  assign full  = (count == (cre_pkg::QUEUE_AW+1)'(cre_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) begin
      slots[wptr] <= din;
    end
  end

endmodule

FILE: rtl/core/cre_back.sv
// Pixel walker: latches fills and issues one pixel write per advance word while a fill is active.
module cre_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           row_pitch,
  input  logic                  q_valid,
  input  cre_pkg::cmd_t         q_word,
  output logic                  q_pop,
  output cre_pkg::back_status_t status,
  cre_pix_if.source             pix
);

  logic        busy;
  logic [12:0] cur_col;
  logic [12:0] cur_row;
  logic [12:0] left_col;
  logic [12:0] right_col;
  logic [12:0] bottom_row;
  logic [27:0] row_base;
  logic [31:0] pixel_word;
  logic [1:0]  fmt;

  logic        out_valid;
  logic [27:0] out_address;
  logic [31:0] out_data;
  logic [2:0]  out_bytes;
  logic        out_last;

  logic        out_free;
  logic        emit;
  logic [13:0] col_inc;
  logic [13:0] row_inc;
  logic [14:0] col_offset;
  logic [2:0]  bytes_c;
  logic        last_c;
  logic [28:0] fill_base;

  assign out_free = !out_valid || pix.ready;
  assign q_pop    = q_valid && ((q_word.kind != cre_pkg::KIND_ADVANCE) || !busy || out_free);
  assign emit     = q_pop && (q_word.kind == cre_pkg::KIND_ADVANCE) && busy;
  assign status   = '{busy: busy, pop: q_pop};

  assign pix.valid         = out_valid;
  assign pix.write_address = out_address;
  assign pix.write_data    = out_data;
  assign pix.write_bytes   = out_bytes;
  assign pix.last_pixel    = out_last;

  always_comb begin
    col_inc   = {1'b0, cur_col} + 14'd1;
    row_inc   = {1'b0, cur_row} + 14'd1;
    last_c    = (col_inc == {1'b0, right_col}) && (row_inc == {1'b0, bottom_row});
    fill_base = q_word.top * row_pitch;
    case (fmt)
      cre_pkg::FMT_32: begin
        bytes_c    = 3'd4;
        col_offset = {cur_col, 2'b00};
      end
      cre_pkg::FMT_24: begin
        bytes_c    = 3'd3;
        col_offset = {1'b0, cur_col, 1'b0} + {2'b00, cur_col};
      end
      default: begin
        bytes_c    = 3'd2;
        col_offset = {1'b0, cur_col, 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        case (q_word.kind)
          cre_pkg::KIND_FILL: busy <= 1'b1;
          cre_pkg::KIND_CLEAR: busy <= 1'b0;
          default: begin
            if (busy && (col_inc >= {1'b0, right_col}) && (row_inc >= {1'b0, bottom_row})) begin
              busy <= 1'b0;
            end
          end
        endcase
      end
    end

    if (q_pop && (q_word.kind == cre_pkg::KIND_FILL)) begin
      left_col   <= q_word.left;
      right_col  <= q_word.right;
      bottom_row <= q_word.bottom;
      cur_col    <= q_word.left;
      cur_row    <= q_word.top;
      row_base   <= fill_base[27:0];
      pixel_word <= q_word.pixel;
      fmt        <= q_word.fmt;
    end else if (emit) begin
      if (col_inc >= {1'b0, right_col}) begin
        cur_col  <= left_col;
        cur_row  <= row_inc[12:0];
        row_base <= row_base + {12'h000, row_pitch};
      end else begin
        cur_col <= col_inc[12:0];
      end
    end

    if (emit) begin
      out_address <= row_base + {13'h0, col_offset};
      out_data    <= pixel_word;
      out_bytes   <= bytes_c;
      out_last    <= last_c;
    end
  end

endmodule

FILE: sim/tb_clipped_rect_fill_engine.sv
// Testbench for clipped_rect_fill_engine: random fills checked against a local fill model.
module tb_clipped_rect_fill_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {PACE_FULL, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  typedef struct {
    logic               func;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [31:0]        color;
  } fill_cmd_t;

  typedef struct packed {
    logic [27:0] addr;
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } pixel_write_t;

  logic clk;
  logic rst;

  cre_cmd_if cmd_ch();
  cre_pix_if pix_ch();
  cre_cfg_if cfg_ch();

  clipped_rect_fill_engine dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .pix(pix_ch),
    .cfg(cfg_ch)
  );

  fill_cmd_t    queued_cmds[$];
  pixel_write_t owed_writes[$];
  int           cmds_queued = 0;
  int           cmds_taken = 0;
  int           errors = 0;
  pace_t        pace = PACE_FULL;

  // Local copy of the register file.
  logic [12:0] scr_width = 13'd640;
  logic [12:0] scr_height = 13'd480;
  logic [15:0] pitch = 16'd2560;
  logic [1:0]  fmt = cre_pkg::FMT_32;
  logic        clip_en = 1'b0;
  logic [25:0] clip_x = '0;
  logic [25:0] clip_y = '0;

  // Local fill state.
  logic        filling = 1'b0;
  logic [12:0] col = '0;
  logic [12:0] row = '0;
  logic [12:0] left_col = '0;
  logic [12:0] right_col = '0;
  logic [12:0] bottom_row = '0;
  logic [27:0] row_addr = '0;
  logic [31:0] pix_word = '0;
  logic [1:0]  fill_fmt = cre_pkg::FMT_32;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit skip_cycle(input bit rx_side);
    int pct;
    case (pace)
      PACE_SENDER:   pct = rx_side ? 0 : 45;
      PACE_RECEIVER: pct = rx_side ? 45 : 0;
      PACE_BOTH:     pct = 8;
      default:       pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  // Clips the requested rectangle and latches the fill; an empty result ends any fill.
  task automatic start_fill(input fill_cmd_t c);
    int x, y, w, h, sw, sh, x1, y1, x2, y2, cx1, cx2, cy1, cy2;
    x = c.x;
    y = c.y;
    w = c.w;
    h = c.h;
    sw = (scr_width > cre_pkg::MAX_DIM) ? cre_pkg::MAX_DIM : scr_width;
    sh = (scr_height > cre_pkg::MAX_DIM) ? cre_pkg::MAX_DIM : scr_height;
    filling = 1'b0;
    if (w <= 0 || h <= 0 || fmt == cre_pkg::FMT_NONE) return;
    x1 = (x < 0) ? 0 : x;
    y1 = (y < 0) ? 0 : y;
    x2 = (x + w > sw) ? sw : x + w;
    y2 = (y + h > sh) ? sh : y + h;
    if (clip_en) begin
      cx1 = clip_x[12:0];
      cx2 = clip_x[25:13];
      cy1 = clip_y[12:0];
      cy2 = clip_y[25:13];
      if (x1 < cx1) x1 = cx1;
      if (y1 < cy1) y1 = cy1;
      if (x2 > cx2) x2 = cx2;
      if (y2 > cy2) y2 = cy2;
    end
    if (x2 <= x1 || y2 <= y1) return;
    left_col = 13'(x1);
    right_col = 13'(x2);
    bottom_row = 13'(y2);
    col = 13'(x1);
    row = 13'(y1);
    row_addr = 28'(y1 * pitch);
    fill_fmt = fmt;
    case (fmt)
      cre_pkg::FMT_32: pix_word = c.color;
      cre_pkg::FMT_24: pix_word = {8'h00, c.color[23:0]};
      default: pix_word = {16'h0000, c.color[23:19], c.color[15:10], c.color[7:3]};
    endcase
    filling = 1'b1;
  endtask

  task automatic advance_fill();
    pixel_write_t pw;
    int nb;
    if (!filling) return;
    nb = (fill_fmt == cre_pkg::FMT_32) ? 4 : (fill_fmt == cre_pkg::FMT_24) ? 3 : 2;
    pw.addr = 28'(row_addr + col * nb);
    pw.data = pix_word;
    pw.nbytes = 3'(nb);
    pw.last = (col + 1 == right_col) && (row + 1 == bottom_row);
    owed_writes.push_back(pw);
    col = col + 1'b1;
    if (col >= right_col) begin
      col = left_col;
      row = row + 1'b1;
      row_addr = row_addr + {12'h000, pitch};
      if (row >= bottom_row) filling = 1'b0;
    end
  endtask

  // Command side: the fill model advances at each accepted word.
  always @(posedge clk) begin : drive_cmds
    fill_cmd_t c;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        c.func = cmd_ch.func;
        c.x = cmd_ch.rect_x;
        c.y = cmd_ch.rect_y;
        c.w = cmd_ch.rect_w;
        c.h = cmd_ch.rect_h;
        c.color = cmd_ch.fill_color;
        if (c.func == cre_pkg::FUNC_START) start_fill(c);
        else advance_fill();
        cmds_taken++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (queued_cmds.size() > 0 && !skip_cycle(1'b0)) begin
          c = queued_cmds.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.func <= c.func;
          cmd_ch.rect_x <= c.x;
          cmd_ch.rect_y <= c.y;
          cmd_ch.rect_w <= c.w;
          cmd_ch.rect_h <= c.h;
          cmd_ch.fill_color <= c.color;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Pixel side: every accepted write must match the oldest owed write.
  always @(posedge clk) begin : check_writes
    pixel_write_t got, want;
    if (!rst) begin
      if (pix_ch.valid && pix_ch.ready) begin
        got = {pix_ch.write_address, pix_ch.write_data, pix_ch.write_bytes,
               pix_ch.last_pixel};
        if (owed_writes.size() == 0) begin
          errors++;
          $display("%0t: unexpected write: expected none, got addr=%h data=%h %s",
                   $time, got.addr, got.data,
                   $sformatf("bytes=%0d last=%0b", got.nbytes, got.last));
        end else begin
          want = owed_writes.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: write mismatch: expected addr=%h data=%h bytes=%0d last=%0b,",
                     $time, want.addr, want.data, want.nbytes, want.last);
            $display("%0t:   got addr=%h data=%h bytes=%0d last=%0b",
                     $time, got.addr, got.data, got.nbytes, got.last);
          end
        end
      end
      pix_ch.ready <= !skip_cycle(1'b1);
    end
  end

  task automatic push_cmd(input logic f, input int x, y, w, h, input logic [31:0] color);
    fill_cmd_t c;
    c.func = f;
    c.x = 16'(x);
    c.y = 16'(y);
    c.w = 16'(w);
    c.h = 16'(h);
    c.color = color;
    queued_cmds.push_back(c);
    cmds_queued++;
  endtask

  task automatic push_advance();
    push_cmd(cre_pkg::FUNC_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Mostly a start followed by enough advances to finish it, placed around the drawable area.
  task automatic add_fills(input int count);
    int lo_x, hi_x, lo_y, hi_y, x, y, w, h, steps, added;
    added = 0;
    while (added < count) begin
      lo_x = 0;
      lo_y = 0;
      hi_x = (scr_width > cre_pkg::MAX_DIM) ? cre_pkg::MAX_DIM : scr_width;
      hi_y = (scr_height > cre_pkg::MAX_DIM) ? cre_pkg::MAX_DIM : scr_height;
      if (clip_en && clip_x[25:13] > clip_x[12:0]) begin
        lo_x = clip_x[12:0];
        hi_x = clip_x[25:13];
      end
      if (clip_en && clip_y[25:13] > clip_y[12:0]) begin
        lo_y = clip_y[12:0];
        hi_y = clip_y[25:13];
      end
      if ($urandom_range(9) == 0) begin
        push_cmd(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom, $urandom);
        added++;
      end else begin
        x = lo_x - 3 + $urandom_range(hi_x - lo_x + 4);
        y = lo_y - 2 + $urandom_range(hi_y - lo_y + 2);
        w = $urandom_range(8, 1);
        h = $urandom_range(4, 1);
        if ($urandom_range(11) == 0) w = -$urandom_range(2);
        if ($urandom_range(11) == 0) h = -$urandom_range(2);
        steps = (w > 0 && h > 0) ? w * h : 1;
        case ($urandom_range(5))
          0: steps = $urandom_range(steps - 1);
          1: steps = steps + $urandom_range(2, 1);
          default: ;
        endcase
        push_cmd(cre_pkg::FUNC_START, x, y, w, h, $urandom);
        repeat (steps) push_advance();
        added += steps + 1;
      end
    end
  endtask

  // Called at a rising edge; returns at the edge that accepts the word, with valid still high.
  task automatic write_reg(input logic [2:0] idx, input logic [25:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      cre_pkg::REG_SCREEN_WIDTH:  scr_width = value[12:0];
      cre_pkg::REG_SCREEN_HEIGHT: scr_height = value[12:0];
      cre_pkg::REG_ROW_PITCH:     pitch = value[15:0];
      cre_pkg::REG_PIXEL_FORMAT:  fmt = value[1:0];
      cre_pkg::REG_CLIP_ON:       clip_en = value[0];
      cre_pkg::REG_CLIP_X_BOUNDS: clip_x = value;
      cre_pkg::REG_CLIP_Y_BOUNDS: clip_y = value;
      default: ;
    endcase
  endtask

  // Unused upper data bits carry random values.
  function automatic logic [25:0] pad_junk(input logic [25:0] v, input int bits);
    return 26'(v | ($urandom << bits));
  endfunction

  task automatic load_config(input int w, h, p, input logic [1:0] f, input logic c,
                             input logic [25:0] xb, yb);
    write_reg(cre_pkg::REG_SCREEN_WIDTH, pad_junk(26'(w[12:0]), 13));
    write_reg(cre_pkg::REG_SCREEN_HEIGHT, pad_junk(26'(h[12:0]), 13));
    write_reg(cre_pkg::REG_ROW_PITCH, pad_junk(26'(p[15:0]), 16));
    write_reg(cre_pkg::REG_PIXEL_FORMAT, pad_junk(26'(f), 2));
    write_reg(cre_pkg::REG_CLIP_ON, pad_junk(26'(c), 1));
    write_reg(cre_pkg::REG_CLIP_X_BOUNDS, xb);
    write_reg(cre_pkg::REG_CLIP_Y_BOUNDS, yb);
    cfg_ch.valid <= 1'b0;
  endtask

  // Waits until every word is taken and every write has come, then lets the pipeline empty.
  task automatic settle();
    int spins;
    while (cmds_taken != cmds_queued) @(posedge clk);
    spins = 0;
    while (owed_writes.size() != 0 && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
    repeat (12) @(posedge clk);
  endtask

  initial begin : stimulus
    int w, h, ew, eh, cx1, cx2, cy1, cy2;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.func = cre_pkg::FUNC_START;
    cmd_ch.rect_x = '0;
    cmd_ch.rect_y = '0;
    cmd_ch.rect_w = '0;
    cmd_ch.rect_h = '0;
    cmd_ch.fill_color = '0;
    pix_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = cre_pkg::REG_SCREEN_WIDTH;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset configuration.
    push_cmd(cre_pkg::FUNC_ADVANCE, 0, 0, 0, 0, 0);
    push_cmd(cre_pkg::FUNC_START, 0, 0, 1, 1, 32'hFFFF_FFFF);
    push_advance();
    push_cmd(cre_pkg::FUNC_START, 638, 478, 32767, 32767, 32'h00A5_C3E1);
    repeat (4) push_advance();
    push_cmd(cre_pkg::FUNC_START, 5, 5, 3, 2, 32'h1234_5678);
    push_advance();
    push_cmd(cre_pkg::FUNC_START, -32768, -32768, 32767, 32767, 32'h0000_0000);
    push_advance();
    push_cmd(cre_pkg::FUNC_START, 10, 10, 0, 5, 32'h8000_0001);
    push_cmd(cre_pkg::FUNC_START, 10, 10, 4, -32768, 32'h7FFF_FFFE);
    push_cmd(cre_pkg::FUNC_START, 32767, 0, 1, 1, 32'hDEAD_BEEF);
    push_cmd(cre_pkg::FUNC_START, 2, 3, 3, 1, 32'hCAFE_F00D);
    push_advance();
    // A new start in the middle of a fill replaces it.
    push_cmd(cre_pkg::FUNC_START, -1, -1, 2, 3, 32'h0F0F_F0F0);
    repeat (3) push_advance();
    add_fills(60);
    settle();

    pace = PACE_SENDER;
    load_config(1, 1, 0, cre_pkg::FMT_24, 1'b0, '0, '0);
    add_fills(40);
    settle();

    pace = PACE_RECEIVER;
    write_reg(REG_UNUSED, 26'($urandom));
    load_config(4096, 4096, 65535, cre_pkg::FMT_565, 1'b1, {13'd4096, 13'd4090},
                {13'd4096, 13'd4092});
    add_fills(80);
    settle();

    // Inverted clip window: nothing is drawn.
    pace = PACE_BOTH;
    load_config(8191, 8191, $urandom_range(65535), cre_pkg::FMT_32, 1'b1,
                {13'd100, 13'd100}, {13'd20, 13'd50});
    add_fills(25);
    settle();

    pace = PACE_FULL;
    load_config(320, 200, 640, cre_pkg::FMT_NONE, 1'b0, '0, '0);
    add_fills(25);
    settle();

    pace = PACE_SENDER;
    load_config(0, 480, 2560, cre_pkg::FMT_32, 1'b0, '0, '0);
    add_fills(20);
    settle();

    for (int p = 0; p < 8; p++) begin
      pace = pace_t'(p % 4);
      w = ($urandom_range(3) == 0) ? $urandom_range(8191, 4097) : $urandom_range(4096, 1);
      h = ($urandom_range(3) == 0) ? $urandom_range(8191, 4097) : $urandom_range(4096, 1);
      ew = (w > 4096) ? 4096 : w;
      eh = (h > 4096) ? 4096 : h;
      cx1 = $urandom_range(ew - 1);
      cx2 = ($urandom_range(5) == 0) ? $urandom_range(cx1) : cx1 + $urandom_range(48, 1);
      cy1 = $urandom_range(eh - 1);
      cy2 = ($urandom_range(5) == 0) ? $urandom_range(cy1) : cy1 + $urandom_range(24, 1);
      load_config(w, h, $urandom_range(65535), 2'($urandom_range(2)),
                  1'($urandom_range(1)),
                  {cx2[12:0], cx1[12:0]}, {cy2[12:0], cy1[12:0]});
      add_fills(60);
      settle();
    end

    if (owed_writes.size() != 0) begin
      errors++;
      $display("%0t: missing writes: expected %0d more, got none", $time, owed_writes.size());
    end
    if (errors == 0) $display("clipped_rect_fill_engine test passed");
    else $display("clipped_rect_fill_engine test failed");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("clipped_rect_fill_engine test failed");
    $finish;
  end

endmodule
